### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define BSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bsp assertion failed");

// clocked assertion, also checked during reset
`define BSP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bsp assertion failed");

`endif

### hw/rtl/bsp_pkg.sv
// types and constants of the box screen bounds projector
package bsp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   // dot product width, enough for the smallest fraction width
   localparam int DOT_W = 58;
   // quotient bits below the sign
   localparam int QBITS = 31;
   // divider: one setup stage, one stage per quotient bit, one sign stage
   localparam int DIV_LAT = QBITS + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int CORNERS = 8;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam logic [13:0] SCREEN_WIDTH_RST = 14'd1920;
   localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd1080;

   typedef enum logic [2:0] {
      CSR_ROW_X_FIRST  = 3'd0,
      CSR_ROW_X_SECOND = 3'd1,
      CSR_ROW_Y_FIRST  = 3'd2,
      CSR_ROW_Y_SECOND = 3'd3,
      CSR_ROW_W_FIRST  = 3'd4,
      CSR_ROW_W_SECOND = 3'd5,
      CSR_SCREEN_W     = 3'd6,
      CSR_SCREEN_H     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [5:0][63:0] row;
      logic [13:0]      width;
      logic [13:0]      height;
   } cfg_type;

   // saturated low and high corners of one box
   typedef struct packed {
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
   } box_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
      logic fail;
   } tag_type;

   typedef struct packed {
      tag_type            tag;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
   } corner_type;

endpackage

### hw/rtl/bsp_front.sv
// front end: takes box transactions, forms corners, queues them
module bsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [31:0]      req_origin_x,
   input  logic [31:0]      req_origin_y,
   input  logic [31:0]      req_origin_z,
   input  logic [31:0]      req_low_x,
   input  logic [31:0]      req_low_y,
   input  logic [31:0]      req_low_z,
   input  logic [31:0]      req_high_x,
   input  logic [31:0]      req_high_y,
   input  logic [31:0]      req_high_z,
   output logic             head_vld,
   output bsp_pkg::box_type head,
   input  logic             pop
);
   import bsp_pkg::*;

   box_type     mem_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   box_type     box_in;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] s;
      s = $signed({a[31], a}) + $signed({b[31], b});
      if (s > 33'sd2147483647) begin
         sat_add = Q_MAX;
      end else if (s < -33'sd2147483648) begin
         sat_add = Q_MIN;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   assign busy = (count_ff == 2'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign head_vld = (count_ff != 2'd0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      box_in.lo[0] = sat_add(req_origin_x, req_low_x);
      box_in.lo[1] = sat_add(req_origin_y, req_low_y);
      box_in.lo[2] = sat_add(req_origin_z, req_low_z);
      box_in.hi[0] = sat_add(req_origin_x, req_high_x);
      box_in.hi[1] = sat_add(req_origin_y, req_high_y);
      box_in.hi[2] = sat_add(req_origin_z, req_high_z);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/bsp_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
module bsp_div #(
   parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       num_neg,
   input  logic [bsp_pkg::DOT_W-1:0]  num_mag,
   input  logic [bsp_pkg::DOT_W-1:0]  den,
   output logic signed [31:0]         quot
);
   import bsp_pkg::*;

   logic [DOT_W-1:0] rem_ff [QBITS+1];
   logic [DOT_W-1:0] mag_ff [QBITS+1];
   logic [DOT_W-1:0] den_ff [QBITS+1];
   logic [QBITS-1:0] q_ff   [QBITS+1];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   logic [DOT_W-1:0] rem0_in;
   logic signed [31:0] quot_ff, quot_in;

   // integer part at or above 2^(31-F) saturates
   assign rem0_in = num_mag >> (QBITS - FRAC_BITS);

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem0_in;
      mag_ff[0] <= num_mag;
      den_ff[0] <= den;
      q_ff[0] <= '0;
      neg_ff[0] <= num_neg;
      ovf_ff[0] <= (rem0_in >= den);
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_stage
      localparam int B = QBITS - 1 - j;
      logic           nbit;
      logic [DOT_W:0] rem2, trial;
      logic           ge;

      if (B >= FRAC_BITS) begin : g_num
         assign nbit = mag_ff[j][B-FRAC_BITS];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      assign rem2 = {rem_ff[j], nbit};
      assign ge = (rem2 >= {1'b0, den_ff[j]});
      assign trial = rem2 - {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? trial[DOT_W-1:0] : rem2[DOT_W-1:0];
         q_ff[j+1] <= {q_ff[j][QBITS-2:0], ge};
         mag_ff[j+1] <= mag_ff[j];
         den_ff[j+1] <= den_ff[j];
         neg_ff[j+1] <= neg_ff[j];
         ovf_ff[j+1] <= ovf_ff[j];
      end
   end

   always_comb begin
      if (ovf_ff[QBITS]) begin
         quot_in = neg_ff[QBITS] ? Q_MIN : Q_MAX;
      end else if (neg_ff[QBITS]) begin
         quot_in = -$signed({1'b0, q_ff[QBITS]});
      end else begin
         quot_in = $signed({1'b0, q_ff[QBITS]});
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

### hw/rtl/bsp_proj.sv
// back end: walks the eight corners and projects one per cycle
module bsp_proj #(
   parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  bsp_pkg::cfg_type    cfg,
   input  logic                head_vld,
   input  bsp_pkg::box_type    head,
   output logic                pop,
   output bsp_pkg::corner_type corner
);
   import bsp_pkg::*;

   localparam int W_MIN = (2 ** FRAC_BITS + 999) / 1000;

   logic [2:0]           k_ff, k_in;
   tag_type              tag0;
   logic signed [31:0]   p [3];

   logic signed [63:0]   prod_ff [3][3];
   tag_type              tag1_ff;
   logic signed [DOT_W-1:0] dot_ff [3], dot_in [3];
   tag_type              tag2_ff;

   logic                 xneg_ff, yneg_ff;
   logic [DOT_W-1:0]     xmag_ff, ymag_ff, den_ff;
   tag_type              tag3_ff, tag3_in;

   tag_type              tagd_ff [DIV_LAT];
   logic signed [31:0]   qx, qy;

   logic signed [46:0]   mx_ff, my_ff;
   tag_type              tag4_ff;
   corner_type           corner_ff, corner_in;

   // corner issue
   assign pop = head_vld && (k_ff == 3'(CORNERS - 1));
   assign k_in = head_vld ? k_ff + 3'd1 : k_ff;

   always_comb begin
      tag0.vld = head_vld;
      tag0.first = (k_ff == 3'd0);
      tag0.last = (k_ff == 3'(CORNERS - 1));
      tag0.fail = 1'b0;
      for (int a = 0; a < 3; a++) begin
         p[a] = k_ff[a] ? $signed(head.hi[a]) : $signed(head.lo[a]);
      end
   end

   // products: rows x, y, w times the corner
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         prod_ff[r][0] <= $signed(cfg.row[2*r][31:0]) * p[0];
         prod_ff[r][1] <= $signed(cfg.row[2*r][63:32]) * p[1];
         prod_ff[r][2] <= $signed(cfg.row[2*r+1][31:0]) * p[2];
      end
   end

   // exact sum, floor shift, plus the translation term
   always_comb begin
      logic signed [65:0] sum;
      logic signed [65:0] shifted;
      logic signed [31:0] c3;
      for (int r = 0; r < 3; r++) begin
         sum = 66'(prod_ff[r][0]);
         sum = sum + 66'(prod_ff[r][1]);
         sum = sum + 66'(prod_ff[r][2]);
         shifted = sum >>> FRAC_BITS;
         c3 = $signed(cfg.row[2*r+1][63:32]);
         dot_in[r] = DOT_W'(shifted) + DOT_W'(c3);
      end
   end

   always_ff @(posedge clock) begin
      dot_ff <= dot_in;
   end

   // w threshold and signs for the dividers
   always_comb begin
      tag3_in = tag2_ff;
      tag3_in.fail = (dot_ff[2] < $signed(DOT_W'(W_MIN)));
   end

   always_ff @(posedge clock) begin
      xneg_ff <= dot_ff[0][DOT_W-1];
      yneg_ff <= dot_ff[1][DOT_W-1];
      xmag_ff <= dot_ff[0][DOT_W-1] ? DOT_W'(-dot_ff[0]) : DOT_W'(dot_ff[0]);
      ymag_ff <= dot_ff[1][DOT_W-1] ? DOT_W'(-dot_ff[1]) : DOT_W'(dot_ff[1]);
      den_ff <= DOT_W'(dot_ff[2]);
   end

   bsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock   (clock),
      .num_neg (xneg_ff),
      .num_mag (xmag_ff),
      .den     (den_ff),
      .quot    (qx)
   );

   bsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock   (clock),
      .num_neg (yneg_ff),
      .num_mag (ymag_ff),
      .den     (den_ff),
      .quot    (qy)
   );

   // viewport scale
   always_ff @(posedge clock) begin
      mx_ff <= 47'(qx) * $signed({33'd0, cfg.width});
      my_ff <= 47'(qy) * $signed({33'd0, cfg.height});
   end

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         sat32 = Q_MAX;
      end else if (v < -48'sd2147483648) begin
         sat32 = Q_MIN;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   always_comb begin
      logic signed [47:0] cx, cy;
      cx = $signed({34'd0, cfg.width}) <<< (FRAC_BITS - 1);
      cy = $signed({34'd0, cfg.height}) <<< (FRAC_BITS - 1);
      corner_in.tag = tag4_ff;
      corner_in.sx = sat32(cx + 48'(mx_ff >>> 1));
      corner_in.sy = sat32(cy - 48'(my_ff >>> 1));
   end

   // control along the pipe
   always_ff @(posedge clock) begin
      corner_ff.sx <= corner_in.sx;
      corner_ff.sy <= corner_in.sy;
      if (reset) begin
         k_ff <= 3'd0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         for (int i = 0; i < DIV_LAT; i++) begin
            tagd_ff[i] <= '0;
         end
         tag4_ff <= '0;
         corner_ff.tag <= '0;
      end else begin
         k_ff <= k_in;
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag3_in;
         tagd_ff[0] <= tag3_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            tagd_ff[i] <= tagd_ff[i-1];
         end
         tag4_ff <= tagd_ff[DIV_LAT-1];
         corner_ff.tag <= corner_in.tag;
      end
   end

   assign corner = corner_ff;

endmodule

### hw/rtl/bsp_reduce.sv
// bounds over the corners of a box and the result register
module bsp_reduce (
   input  logic                clock,
   input  logic                reset,
   input  bsp_pkg::corner_type corner,
   output logic                rsp_strobe,
   output logic                rsp_visible,
   output logic [31:0]         rsp_left,
   output logic [31:0]         rsp_top,
   output logic [31:0]         rsp_right,
   output logic [31:0]         rsp_bottom
);
   import bsp_pkg::*;

   logic signed [31:0] left_ff, left_in, right_ff, right_in;
   logic signed [31:0] top_ff, top_in, bottom_ff, bottom_in;
   logic               ok_ff, ok_in;
   logic               strobe_ff;
   logic               vis_ff;
   logic [31:0]        oleft_ff, otop_ff, oright_ff, obottom_ff;

   always_comb begin
      if (corner.tag.first) begin
         left_in = corner.sx;
         right_in = corner.sx;
         top_in = corner.sy;
         bottom_in = corner.sy;
         ok_in = !corner.tag.fail;
      end else begin
         left_in = (corner.sx < left_ff) ? corner.sx : left_ff;
         right_in = (corner.sx > right_ff) ? corner.sx : right_ff;
         top_in = (corner.sy > top_ff) ? corner.sy : top_ff;
         bottom_in = (corner.sy < bottom_ff) ? corner.sy : bottom_ff;
         ok_in = ok_ff && !corner.tag.fail;
      end
   end

   always_ff @(posedge clock) begin
      if (corner.tag.vld) begin
         left_ff <= left_in;
         right_ff <= right_in;
         top_ff <= top_in;
         bottom_ff <= bottom_in;
         ok_ff <= ok_in;
      end
      if (corner.tag.vld && corner.tag.last) begin
         vis_ff <= ok_in;
         oleft_ff <= ok_in ? left_in : '0;
         otop_ff <= ok_in ? top_in : '0;
         oright_ff <= ok_in ? right_in : '0;
         obottom_ff <= ok_in ? bottom_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= corner.tag.vld && corner.tag.last;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_visible = vis_ff;
   assign rsp_left = oleft_ff;
   assign rsp_top = otop_ff;
   assign rsp_right = oright_ff;
   assign rsp_bottom = obottom_ff;

endmodule

### hw/rtl/box_screen_bounds_projector_top.sv
// box screen bounds projector: registers, front end, projector, bounds
//
// A box transaction is taken at a rising edge with start high and busy low.
// The front end saturates origin plus offsets into low and high corners and
// keeps up to two boxes in a queue, so busy rises only when both are held.
// The projector walks the eight corners of the queue head, one per cycle,
// through the matrix products, two pipelined dividers and the viewport
// scale; the receiver cannot stall, so the pipe never holds.
// The single corner projector sets the box rate; it starts on the next
// box while the one before is still in the pipe. rsp_strobe is high one
// cycle per box. Configuration goes over the APB port, 64-bit registers
// at 8-byte steps. The user must see that it is only written while no
// box is in flight; the block itself does not enforce this.
// Reset (synchronous) empties the queue and the pipe and loads the
// register reset values; no clearing pass is needed.
module box_screen_bounds_projector_top #(
   parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_low_x,
   input  logic [31:0] req_low_y,
   input  logic [31:0] req_low_z,
   input  logic [31:0] req_high_x,
   input  logic [31:0] req_high_y,
   input  logic [31:0] req_high_z,
   output logic        rsp_strobe,
   output logic        rsp_visible,
   output logic [31:0] rsp_left,
   output logic [31:0] rsp_top,
   output logic [31:0] rsp_right,
   output logic [31:0] rsp_bottom,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import bsp_pkg::*;

   cfg_type       cfg_ff;
   logic          cfg_we;
   csr_index_type cfg_idx;
   logic          head_vld;
   box_type       head;
   logic          pop;
   corner_type    corner;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready;
   assign cfg_idx = csr_index_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row <= '0;
         cfg_ff.width <= SCREEN_WIDTH_RST;
         cfg_ff.height <= SCREEN_HEIGHT_RST;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            CSR_SCREEN_W: cfg_ff.width <= pwdata[13:0];
            CSR_SCREEN_H: cfg_ff.height <= pwdata[13:0];
            default: cfg_ff.row[cfg_idx] <= pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         CSR_SCREEN_W: prdata = {50'd0, cfg_ff.width};
         CSR_SCREEN_H: prdata = {50'd0, cfg_ff.height};
         default: prdata = cfg_ff.row[cfg_idx];
      endcase
   end

   bsp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_low_x    (req_low_x),
      .req_low_y    (req_low_y),
      .req_low_z    (req_low_z),
      .req_high_x   (req_high_x),
      .req_high_y   (req_high_y),
      .req_high_z   (req_high_z),
      .head_vld     (head_vld),
      .head         (head),
      .pop          (pop)
   );

   bsp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_vld (head_vld),
      .head     (head),
      .pop      (pop),
      .corner   (corner)
   );

   bsp_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .corner      (corner),
      .rsp_strobe  (rsp_strobe),
      .rsp_visible (rsp_visible),
      .rsp_left    (rsp_left),
      .rsp_top     (rsp_top),
      .rsp_right   (rsp_right),
      .rsp_bottom  (rsp_bottom)
   );

endmodule

### hw/rtl/bsp_checker.sv
// port-level checks of the projector, bound to the top level
`include "assert_macros.svh"

module bsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_strobe,
   input logic        rsp_visible,
   input logic [31:0] rsp_left,
   input logic [31:0] rsp_top,
   input logic [31:0] rsp_right,
   input logic [31:0] rsp_bottom,
   input logic        pready
);

   // results of two transactions never come back to back
   `BSP_ASSERT(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe)

   // hidden box reports an empty rectangle
   `BSP_ASSERT(a_hidden_zero, clock, reset, (rsp_strobe && !rsp_visible) |-> (rsp_left == 32'd0 && rsp_top == 32'd0 && rsp_right == 32'd0 && rsp_bottom == 32'd0))

   // visible rectangle is ordered
   `BSP_ASSERT(a_ordered, clock, reset, (rsp_strobe && rsp_visible) |-> ($signed(rsp_left) <= $signed(rsp_right) && $signed(rsp_bottom) <= $signed(rsp_top)))

   // nothing comes out right after reset
   `BSP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe)

   `BSP_ASSERT_ALWAYS(a_pready, clock, pready)

endmodule

bind box_screen_bounds_projector_top bsp_checker u_bsp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_strobe  (rsp_strobe),
   .rsp_visible (rsp_visible),
   .rsp_left    (rsp_left),
   .rsp_top     (rsp_top),
   .rsp_right   (rsp_right),
   .rsp_bottom  (rsp_bottom),
   .pready      (pready)
);

### dv/box_screen_bounds_projector_top_tb.sv
// self-checking testbench of the box screen bounds projector
module box_screen_bounds_projector_top_tb;
   import bsp_pkg::*;

   localparam int FB = 16;
   localparam longint W_FLOOR = ((64'd1 << FB) + 999) / 1000;
   localparam longint QHI = 64'sd2147483647;
   localparam longint QLO = -64'sd2147483648;

   typedef struct {
      logic [31:0] f[9];
   } box_req_t;

   typedef struct {
      logic        visible;
      logic [31:0] left;
      logic [31:0] top;
      logic [31:0] right;
      logic [31:0] bottom;
   } bounds_t;

   typedef struct {
      box_req_t b;
      bit       typed;
      bounds_t  r;
   } dir_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_f[9];
   logic        rsp_strobe, rsp_visible;
   logic [31:0] rsp_left, rsp_top, rsp_right, rsp_bottom;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [5:0]  paddr = 0;
   logic [63:0] pwdata = 0;
   logic [63:0] prdata;
   logic        pready;

   logic [63:0] shadow_rows[6];
   logic [13:0] shadow_w, shadow_h;
   bounds_t     bounds_due[$];
   int          mismatches = 0;
   int          sent_boxes = 0;

   initial for (int i = 0; i < 9; i++) req_f[i] = 0;

   always #4 clock = ~clock;

   box_screen_bounds_projector_top i_dut (
      .clock, .reset, .start, .busy,
      .req_origin_x(req_f[0]), .req_origin_y(req_f[1]), .req_origin_z(req_f[2]),
      .req_low_x(req_f[3]), .req_low_y(req_f[4]), .req_low_z(req_f[5]),
      .req_high_x(req_f[6]), .req_high_y(req_f[7]), .req_high_z(req_f[8]),
      .rsp_strobe, .rsp_visible, .rsp_left, .rsp_top, .rsp_right, .rsp_bottom,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   function automatic longint clamp32(longint v);
      if (v > QHI) return QHI;
      if (v < QLO) return QLO;
      return v;
   endfunction

   function automatic longint floor_div2(longint v, int s);
      return v >>> s;
   endfunction

   // exact three-term product, floor scaled, plus the offset coefficient
   function automatic longint matrix_row(logic [63:0] a, logic [63:0] b,
                                         longint p[3]);
      longint c[4];
      logic signed [127:0] acc;
      c[0] = longint'(signed'(a[31:0]));
      c[1] = longint'(signed'(a[63:32]));
      c[2] = longint'(signed'(b[31:0]));
      c[3] = longint'(signed'(b[63:32]));
      acc = 0;
      for (int i = 0; i < 3; i++) acc += 128'(c[i]) * 128'(p[i]);
      acc = acc >>> FB;
      return longint'(acc) + c[3];
   endfunction

   function automatic longint fix_quotient(longint num, longint den);
      bit neg;
      logic [127:0] mag, q;
      neg = num < 0;
      mag = neg ? 128'(-128'(num)) : 128'(num);
      if (mag / den >= (128'd1 << (31 - FB))) return neg ? QLO : QHI;
      q = (mag << FB) / den;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic bounds_t project_box(box_req_t b);
      bounds_t r;
      longint lo[3], hi[3], p[3], w, x, y, sx, sy, l, t, rt, bt, sw, sh;
      bit ok;
      sw = shadow_w;
      sh = shadow_h;
      ok = 1;
      l = 0; t = 0; rt = 0; bt = 0;
      for (int a = 0; a < 3; a++) begin
         lo[a] = clamp32(longint'(signed'(b.f[a])) + longint'(signed'(b.f[3+a])));
         hi[a] = clamp32(longint'(signed'(b.f[a])) + longint'(signed'(b.f[6+a])));
      end
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++) p[a] = k[a] ? hi[a] : lo[a];
         w = matrix_row(shadow_rows[4], shadow_rows[5], p);
         if (w < W_FLOOR) begin
            ok = 0;
            break;
         end
         x = fix_quotient(matrix_row(shadow_rows[0], shadow_rows[1], p), w);
         y = fix_quotient(matrix_row(shadow_rows[2], shadow_rows[3], p), w);
         sx = clamp32(sw * (64'sd1 << (FB - 1)) + floor_div2(x * sw, 1));
         sy = clamp32(sh * (64'sd1 << (FB - 1)) - floor_div2(y * sh, 1));
         if (k == 0) begin
            l = sx; rt = sx; t = sy; bt = sy;
         end else begin
            if (sx < l) l = sx;
            if (sx > rt) rt = sx;
            if (sy > t) t = sy;
            if (sy < bt) bt = sy;
         end
      end
      if (!ok) begin
         l = 0; t = 0; rt = 0; bt = 0;
      end
      r.visible = ok;
      r.left = l[31:0];
      r.top = t[31:0];
      r.right = rt[31:0];
      r.bottom = bt[31:0];
      return r;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [63:0] v);
      start <= 0;
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= 6'(idx) << 3; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (idx <= CSR_ROW_W_SECOND) shadow_rows[idx] = v;
      else if (idx == CSR_SCREEN_W) shadow_w = v[13:0];
      else shadow_h = v[13:0];
   endtask

   // start stays high after the accept; the caller lowers it before any idle cycle
   task automatic send_box(box_req_t b, bit typed, bounds_t want);
      bounds_t due;
      for (int i = 0; i < 9; i++) req_f[i] <= b.f[i];
      start <= 1;
      do @(posedge clock); while (busy);
      due = typed ? want : project_box(b);
      bounds_due = {bounds_due, due};
      sent_boxes++;
   endtask

   task automatic drain_pipe();
      int guard;
      guard = 0;
      start <= 0;
      while (bounds_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // result transaction check
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (bounds_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
         end else begin
            bounds_t e;
            e = bounds_due.pop_front();
            if (e.visible !== rsp_visible || e.left !== rsp_left ||
                e.top !== rsp_top || e.right !== rsp_right ||
                e.bottom !== rsp_bottom) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0b %h %h %h %h got %0b %h %h %h %h",
                     e.visible, e.left, e.top, e.right, e.bottom, rsp_visible,
                     rsp_left, rsp_top, rsp_right, rsp_bottom);
            end
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
         default: return 32'($signed($urandom_range(2 ** 20)) - 2 ** 19);
      endcase
   endfunction

   function automatic box_req_t rand_box(bit wild);
      box_req_t b;
      for (int i = 0; i < 9; i++) b.f[i] = wild ? $urandom : rand_coord();
      return b;
   endfunction

   function automatic logic [63:0] rand_row(bit wild, bit w_row);
      logic [31:0] c0, c1;
      if (wild) return {$urandom, $urandom};
      c0 = 32'($signed($urandom_range(2 ** 18)) - 2 ** 17);
      c1 = 32'($signed($urandom_range(2 ** 18)) - 2 ** 17);
      return w_row ? {c1 >>> 4, c0 >>> 4} : {c1, c0};
   endfunction

   task automatic random_setting(int mode);
      logic [63:0] w2;
      for (int i = 0; i < 4; i++)
         csr_write(csr_index_type'(i), rand_row(mode == 3, 0));
      csr_write(CSR_ROW_W_FIRST, rand_row(mode == 3, 1));
      // positive offset keeps most corners in front of the eye
      w2 = {32'($urandom_range(2 ** 26, 2 ** 20)), 32'($signed($urandom_range(4096)) - 2048)};
      csr_write(CSR_ROW_W_SECOND, mode == 3 ? {$urandom, $urandom} : w2);
      case (mode)
         0: begin csr_write(CSR_SCREEN_W, 14'd8192); csr_write(CSR_SCREEN_H, 14'd8192); end
         1: begin csr_write(CSR_SCREEN_W, 14'd1); csr_write(CSR_SCREEN_H, 14'd1); end
         2: begin csr_write(CSR_SCREEN_W, 14'd0); csr_write(CSR_SCREEN_H, 14'h3fff); end
         default: begin
            csr_write(CSR_SCREEN_W, 14'($urandom));
            csr_write(CSR_SCREEN_H, 14'($urandom));
         end
      endcase
   endtask

   initial begin
      dir_row_t rows[$];
      dir_row_t d;
      bounds_t zero_r;
      int gap, burst;
      zero_r = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
      for (int i = 0; i < 6; i++) shadow_rows[i] = 0;
      shadow_w = SCREEN_WIDTH_RST;
      shadow_h = SCREEN_HEIGHT_RST;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // after reset the w row is zero, so every box fails
      for (int i = 0; i < 9; i++) d.b.f[i] = 0;
      d.typed = 1; d.r = zero_r;
      rows = {rows, d};
      for (int i = 0; i < 9; i++) d.b.f[i] = 32'h7fff_ffff;
      rows = {rows, d};
      for (int i = 0; i < 9; i++) d.b.f[i] = 32'h8000_0000;
      rows = {rows, d};
      foreach (rows[i]) send_box(rows[i].b, rows[i].typed, rows[i].r);
      drain_pipe();

      // identity-like projection with w = 1.0
      csr_write(CSR_ROW_X_FIRST, {32'h0, 32'h0001_0000});
      csr_write(CSR_ROW_X_SECOND, 64'h0);
      csr_write(CSR_ROW_Y_FIRST, {32'h0001_0000, 32'h0});
      csr_write(CSR_ROW_Y_SECOND, 64'h0);
      csr_write(CSR_ROW_W_FIRST, 64'h0);
      csr_write(CSR_ROW_W_SECOND, {32'h0001_0000, 32'h0});
      rows.delete();
      d.typed = 0;
      for (int k = 0; k < 12; k++) begin
         for (int i = 0; i < 9; i++)
            case (k % 4)
               0: d.b.f[i] = 32'h0;
               1: d.b.f[i] = (i >= 6) ? 32'h0000_8000 : 32'hffff_8000;
               // inverted box and saturating corner sums
               2: d.b.f[i] = (i >= 6) ? 32'h8000_0000 : 32'h7fff_ffff;
               default: d.b.f[i] = rand_coord();
            endcase
         rows = {rows, d};
      end
      foreach (rows[i]) send_box(rows[i].b, rows[i].typed, rows[i].r);
      drain_pipe();
      // w below the threshold by one on every corner, then exactly on it
      csr_write(CSR_ROW_W_SECOND, {32'(W_FLOOR - 1), 32'h0});
      d.typed = 1; d.r = zero_r;
      for (int i = 0; i < 9; i++) d.b.f[i] = 0;
      send_box(d.b, 1, zero_r);
      drain_pipe();
      csr_write(CSR_ROW_W_SECOND, {32'(W_FLOOR), 32'h0});
      send_box(d.b, 0, zero_r);
      drain_pipe();

      for (int ph = 0; ph < 8; ph++) begin
         random_setting(ph % 4);
         burst = 0;
         for (int n = 0; n < 112; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(20, 1);
               gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
               if (gap > 0) start <= 0;
               repeat (gap) @(posedge clock);
               // let the pipe run empty before the next burst now and then
               if ($urandom_range(15) == 0) drain_pipe();
            end
            burst--;
            send_box(rand_box($urandom_range(9) == 0), 0, zero_r);
         end
         drain_pipe();
      end

      if (mismatches == 0 && bounds_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
